@@ rtl/core/keyed_first_fit_heap_allocator_unit_assert.svh @@
// Assertion macros used by the checker file kffa_checker.sv.
`ifndef KEYED_FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define KEYED_FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KFFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KFFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/kffa_pkg.sv @@
`default_nettype none
package kffa_pkg;

	localparam int KEY_SLOTS       = 16;
	localparam int HEAP_BYTES      = 4096;
	localparam int GRANULE_BYTES   = 8;
	localparam int MIN_BLOCK_BYTES = 16;
	localparam int HEADER_BYTES    = 8;

	localparam int HEAP_GRANS = HEAP_BYTES / GRANULE_BYTES;
	localparam int GRAN_AW    = $clog2(HEAP_GRANS);
	localparam int GRAN_W     = GRAN_AW + 1;
	localparam int GRAN_SH    = $clog2(GRANULE_BYTES);
	localparam int KEY_IW     = $clog2(KEY_SLOTS);
	localparam int MIN_BLK    =
		(MIN_BLOCK_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;

	localparam int ACTION_W = 2;
	localparam int KEY_W    = 5;
	localparam int SIZE_W   = 13;
	localparam int OFF_W    = 12;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 13;

	localparam logic [GRAN_W-1:0] NIL_GRAN = GRAN_W'(HEAP_GRANS);

	localparam logic [ACTION_W-1:0] ACT_INIT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd4;

	localparam logic CFG_KEY_LIMIT  = 1'b0;
	localparam logic CFG_HEAP_BYTES = 1'b1;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [KEY_W-1:0]    key;
		logic [SIZE_W-1:0]   request_size;
		logic [SIZE_W-1:0]   capacity;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    payload_off;
		logic [SIZE_W-1:0]   data_bytes;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_REL_BSZ,
		S_REL_WALK,
		S_REL_LAT,
		S_REL_WB,
		S_REL_WP,
		S_ALLOC_CHK,
		S_AL_WALK,
		S_AL_LAT,
		S_AL_SPLIT,
		S_AL_LINK,
		S_AL_FIN,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/core/kffa_ram.sv @@
`default_nettype none
module kffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/keyed_first_fit_heap_allocator_unit.sv @@
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | in_data (action, key, request_size, capacity)
// out     | output    | out_valid / out_stall | out_data (status, payload_off, data_bytes)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// Init, lookup and key rejects go from S_DECODE straight to S_DONE. Remove walks the
// free blocks below the freed block; insert walks the free blocks it skips, takes
// S_AL_LINK on a split, stops at no_mem or a zero size, and over a live key runs the
// remove walk first. Each walk step reads the header RAM and waits for it in a LAT state.
// Reset leaves the heap unformatted: issue an init first. in_stall is high from the
// transfer until the result loads; a result waits in the output register under out_stall.
`default_nettype none
module keyed_first_fit_heap_allocator_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire kffa_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output kffa_pkg::out_item_t       out_data,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [kffa_pkg::CFG_W-1:0] cfg_data
);
	import kffa_pkg::*;

	state_t state_q, state_d;
	in_item_t item_q, item_d;
	out_item_t res_q, res_d;
	logic out_valid_q, out_valid_d;
	out_item_t out_data_q, out_data_d;

	logic [KEY_W-1:0]  key_limit_q;
	logic [SIZE_W-1:0] heap_bytes_q;

	logic [KEY_SLOTS-1:0] slot_valid_q, slot_valid_d;
	logic [OFF_W-1:0]     slot_off_q   [KEY_SLOTS];
	logic [SIZE_W-1:0]    slot_bytes_q [KEY_SLOTS];
	logic                 slot_we;

	logic [GRAN_W-1:0]  head_q, head_d;
	logic [GRAN_W-1:0]  cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
	logic [GRAN_W-1:0]  curnext_q, curnext_d, blink_q, blink_d, nb_q, nb_d;
	logic [GRAN_AW-1:0] blk_q, blk_d;
	logic [SIZE_W-1:0]  bsize_q, bsize_d, prevsize_q, prevsize_d, cursize_q, cursize_d;
	logic [SIZE_W:0]    total_q, total_d;

	logic               sz_we, nx_we;
	logic [GRAN_AW-1:0] sz_waddr, nx_waddr, rd_addr;
	logic [SIZE_W-1:0]  sz_wdata, sz_rd;
	logic [GRAN_W-1:0]  nx_wdata, nx_rd;

	logic [KEY_W-1:0]   lim;
	logic               key_ok;
	logic [KEY_IW-1:0]  kidx;
	logic [SIZE_W-1:0]  eff;
	logic [GRAN_W-1:0]  head_cl, next_cl;
	logic               cur_live, walk_more, fit;
	logic [SIZE_W:0]    t_raw, t_round;
	logic [SIZE_W-1:0]  rem;
	logic [GRAN_W+1:0]  nb_sum;
	logic [SIZE_W:0]    end_b, end_p;

	kffa_ram #(.WIDTH(SIZE_W), .DEPTH(HEAP_GRANS)) u_size_ram (
		.clk   (clk),
		.we    (sz_we),
		.waddr (sz_waddr),
		.wdata (sz_wdata),
		.raddr (rd_addr),
		.rdata (sz_rd)
	);

	kffa_ram #(.WIDTH(GRAN_W), .DEPTH(HEAP_GRANS)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (rd_addr),
		.rdata (nx_rd)
	);

	assign lim     = (key_limit_q > KEY_W'(KEY_SLOTS)) ? KEY_W'(KEY_SLOTS) : key_limit_q;
	assign key_ok  = item_q.key < lim;
	assign kidx    = item_q.key[KEY_IW-1:0];
	assign eff     = ((heap_bytes_q > SIZE_W'(HEAP_BYTES)) ? SIZE_W'(HEAP_BYTES) : heap_bytes_q)
		& ~SIZE_W'(GRANULE_BYTES - 1);
	assign head_cl = (head_q < NIL_GRAN) ? head_q : NIL_GRAN;
	assign next_cl = (nx_rd < NIL_GRAN) ? nx_rd : NIL_GRAN;
	assign cur_live  = cur_q < NIL_GRAN;
	assign walk_more = cur_live && (steps_q < NIL_GRAN);
	assign fit     = {1'b0, sz_rd} >= total_q;
	assign t_raw   = (SIZE_W+1)'(HEADER_BYTES) + {1'b0, item_q.request_size}
		+ (SIZE_W+1)'(GRANULE_BYTES - 1);
	assign t_round = t_raw & ~(SIZE_W+1)'(GRANULE_BYTES - 1);
	assign rem     = cursize_q - total_q[SIZE_W-1:0];
	assign nb_sum  = (GRAN_W+2)'(cur_q) + (GRAN_W+2)'(total_q >> GRAN_SH);
	assign end_b   = (SIZE_W+1)'({blk_q, GRAN_SH'(0)}) + (SIZE_W+1)'(bsize_q);
	assign end_p   = (SIZE_W+1)'({prev_q[GRAN_AW-1:0], GRAN_SH'(0)}) + (SIZE_W+1)'(prevsize_q);

	always_comb begin
		state_d    = state_q;
		item_d     = item_q;
		res_d      = res_q;
		head_d     = head_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		steps_d    = steps_q;
		curnext_d  = curnext_q;
		blink_d    = blink_q;
		nb_d       = nb_q;
		blk_d      = blk_q;
		bsize_d    = bsize_q;
		prevsize_d = prevsize_q;
		cursize_d  = cursize_q;
		total_d    = total_q;
		slot_valid_d = slot_valid_q;
		slot_we    = 1'b0;
		sz_we      = 1'b0;
		sz_waddr   = cur_q[GRAN_AW-1:0];
		sz_wdata   = total_q[SIZE_W-1:0];
		nx_we      = 1'b0;
		nx_waddr   = prev_q[GRAN_AW-1:0];
		nx_wdata   = cur_q;
		rd_addr    = cur_q[GRAN_AW-1:0];
		out_valid_d = out_valid_q && out_stall;
		out_data_d  = out_data_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					item_d  = in_data;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_d   = '0;
				blk_d   = slot_off_q[kidx][OFF_W-1:GRAN_SH];
				rd_addr = slot_off_q[kidx][OFF_W-1:GRAN_SH];
				cur_d   = head_cl;
				prev_d  = NIL_GRAN;
				steps_d = '0;
				state_d = S_DONE;
				unique case (item_q.action)
					ACT_INIT: begin
						if (lim == '0) begin
							res_d.status = ST_INVALID;
						end else if (eff < SIZE_W'(MIN_BLK)) begin
							res_d.status     = ST_TOO_SMALL;
							res_d.data_bytes = SIZE_W'(MIN_BLK);
						end else begin
							sz_we        = 1'b1;
							sz_waddr     = '0;
							sz_wdata     = eff;
							nx_we        = 1'b1;
							nx_waddr     = '0;
							nx_wdata     = NIL_GRAN;
							head_d       = '0;
							slot_valid_d = '0;
						end
					end
					ACT_INSERT: begin
						if (!key_ok) begin
							res_d.status = ST_INVALID;
						end else if (slot_valid_q[kidx]) begin
							state_d = S_REL_BSZ;
						end else begin
							state_d = S_ALLOC_CHK;
						end
					end
					ACT_LOOKUP: begin
						if (!key_ok || !slot_valid_q[kidx]) begin
							res_d.status = ST_NOT_FOUND;
						end else if (item_q.capacity < slot_bytes_q[kidx]) begin
							res_d.status     = ST_TOO_SMALL;
							res_d.data_bytes = slot_bytes_q[kidx];
						end else begin
							res_d.payload_off = slot_off_q[kidx] + OFF_W'(HEADER_BYTES);
							res_d.data_bytes  = slot_bytes_q[kidx];
						end
					end
					ACT_REMOVE: begin
						if (!key_ok) begin
							res_d.status = ST_INVALID;
						end else if (!slot_valid_q[kidx]) begin
							res_d.status = ST_NOT_FOUND;
						end else begin
							state_d = S_REL_BSZ;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_REL_BSZ: begin
				bsize_d = sz_rd;
				state_d = S_REL_WALK;
			end
			S_REL_WALK: begin
				state_d = S_REL_LAT;
			end
			S_REL_LAT: begin
				if (walk_more && (cur_q < {1'b0, blk_q})) begin
					prev_d     = cur_q;
					prevsize_d = sz_rd;
					cur_d      = next_cl;
					steps_d    = steps_q + 1'b1;
					state_d    = S_REL_WALK;
				end else begin
					cursize_d = sz_rd;
					curnext_d = next_cl;
					state_d   = S_REL_WB;
				end
			end
			S_REL_WB: begin
				sz_we    = 1'b1;
				sz_waddr = blk_q;
				nx_we    = 1'b1;
				nx_waddr = blk_q;
				if (cur_live && end_b == (SIZE_W+1)'({cur_q[GRAN_AW-1:0], GRAN_SH'(0)})) begin
					bsize_d  = bsize_q + cursize_q;
					blink_d  = curnext_q;
				end else begin
					blink_d  = cur_q;
				end
				sz_wdata = bsize_d;
				nx_wdata = blink_d;
				state_d  = S_REL_WP;
			end
			S_REL_WP: begin
				if (prev_q < NIL_GRAN && end_p == (SIZE_W+1)'({blk_q, GRAN_SH'(0)})) begin
					sz_we    = 1'b1;
					sz_waddr = prev_q[GRAN_AW-1:0];
					sz_wdata = prevsize_q + bsize_q;
					nx_we    = 1'b1;
					nx_wdata = blink_q;
				end else if (prev_q < NIL_GRAN) begin
					nx_we    = 1'b1;
					nx_wdata = {1'b0, blk_q};
				end else begin
					head_d   = {1'b0, blk_q};
				end
				slot_valid_d[kidx] = 1'b0;
				state_d = (item_q.action == ACT_INSERT) ? S_ALLOC_CHK : S_DONE;
			end
			S_ALLOC_CHK: begin
				cur_d   = head_cl;
				prev_d  = NIL_GRAN;
				steps_d = '0;
				total_d = (t_round < (SIZE_W+1)'(MIN_BLK)) ? (SIZE_W+1)'(MIN_BLK) : t_round;
				if (item_q.request_size == '0) begin
					res_d.status = ST_INVALID;
					state_d      = S_DONE;
				end else begin
					state_d = S_AL_WALK;
				end
			end
			S_AL_WALK: begin
				state_d = S_AL_LAT;
			end
			S_AL_LAT: begin
				if (walk_more && !fit) begin
					prev_d  = cur_q;
					cur_d   = next_cl;
					steps_d = steps_q + 1'b1;
					state_d = S_AL_WALK;
				end else if (!cur_live || !fit) begin
					res_d.status = ST_NO_MEM;
					state_d      = S_DONE;
				end else begin
					cursize_d = sz_rd;
					curnext_d = next_cl;
					state_d   = S_AL_SPLIT;
				end
			end
			S_AL_SPLIT: begin
				nb_d = nb_sum[GRAN_W-1:0];
				if (rem >= SIZE_W'(MIN_BLK) && nb_sum < (GRAN_W+2)'(NIL_GRAN)) begin
					sz_we    = 1'b1;
					sz_waddr = nb_sum[GRAN_AW-1:0];
					sz_wdata = rem;
					nx_we    = 1'b1;
					nx_waddr = nb_sum[GRAN_AW-1:0];
					nx_wdata = curnext_q;
					state_d  = S_AL_LINK;
				end else begin
					if (prev_q < NIL_GRAN) begin
						nx_we    = 1'b1;
						nx_wdata = curnext_q;
					end else begin
						head_d = curnext_q;
					end
					state_d = S_AL_FIN;
				end
			end
			S_AL_LINK: begin
				sz_we = 1'b1;
				if (prev_q < NIL_GRAN) begin
					nx_we    = 1'b1;
					nx_wdata = nb_q;
				end else begin
					head_d = nb_q;
				end
				state_d = S_AL_FIN;
			end
			S_AL_FIN: begin
				slot_we            = 1'b1;
				slot_valid_d[kidx] = 1'b1;
				res_d.status       = ST_OK;
				res_d.payload_off  = {cur_q[GRAN_AW-1:0], GRAN_SH'(0)} + OFF_W'(HEADER_BYTES);
				res_d.data_bytes   = item_q.request_size;
				state_d            = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					out_data_d  = res_q;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			slot_valid_q <= '0;
			head_q       <= '0;
			key_limit_q  <= KEY_W'(KEY_SLOTS);
			heap_bytes_q <= SIZE_W'(HEAP_BYTES);
		end else begin
			state_q      <= state_d;
			out_valid_q  <= out_valid_d;
			slot_valid_q <= slot_valid_d;
			head_q       <= head_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_KEY_LIMIT:  key_limit_q  <= cfg_data[KEY_W-1:0];
					CFG_HEAP_BYTES: heap_bytes_q <= cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q     <= item_d;
		res_q      <= res_d;
		out_data_q <= out_data_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		steps_q    <= steps_d;
		curnext_q  <= curnext_d;
		blink_q    <= blink_d;
		nb_q       <= nb_d;
		blk_q      <= blk_d;
		bsize_q    <= bsize_d;
		prevsize_q <= prevsize_d;
		cursize_q  <= cursize_d;
		total_q    <= total_d;
		if (slot_we) begin
			slot_off_q[kidx]   <= {cur_q[GRAN_AW-1:0], GRAN_SH'(0)};
			slot_bytes_q[kidx] <= item_q.request_size;
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

@@ rtl/core/kffa_checker.sv @@
`default_nettype none
`include "keyed_first_fit_heap_allocator_unit_assert.svh"
module kffa_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire kffa_pkg::out_item_t out_data
);
	import kffa_pkg::*;

	logic out_held, in_xfer, out_fail, out_empty;

	assign out_held  = out_valid && out_stall;
	assign in_xfer   = in_valid && !in_stall;
	assign out_fail  = out_valid && out_data.status != ST_OK;
	assign out_empty = out_valid && (out_data.status == ST_INVALID
		|| out_data.status == ST_NOT_FOUND || out_data.status == ST_NO_MEM);

	`KFFA_ASSERT_NXT(a_out_hold, out_held, out_valid, "result dropped under stall")
	`KFFA_ASSERT_NXT(a_out_stable, out_held, $stable(out_data), "result changed under stall")
	`KFFA_ASSERT_NXT(a_busy, in_xfer, in_stall, "block ready right after a transfer")
	`KFFA_ASSERT_IMP(a_off_zero, out_fail, out_data.payload_off == '0, "offset on a failure")
	`KFFA_ASSERT_IMP(a_bytes_zero, out_empty, out_data.data_bytes == '0, "size on a failure")

endmodule

bind keyed_first_fit_heap_allocator_unit kffa_checker u_kffa_checker (.*);
`default_nettype wire
